// ===== hdl/sdq_pkg.sv =====
// Shared types and constants for the skyline dominance query unit.
// No dependencies; imported by skyline_dominance_query_unit.
package sdq_pkg;

  // Frontier table depth and derived widths
  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int COORD_W  = 32;
  localparam int SIZE_W   = 9;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_DOMINATED = 2'd1,
    ST_FULL      = 2'd2,
    ST_QUERY     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_e;

endpackage

// ===== hdl/skyline_dominance_query_unit.sv =====
// Skyline dominance query unit: frontier table, scan sequencer and result register.
// Depends on sdq_pkg.
//
// Keeps the 2-D Pareto frontier of inserted signed points in a staircase (x descending,
// y ascending) and answers dominance queries against it. Every beat, insert or query,
// scans the stored frontier once, one entry per cycle from a synchronous table with a
// registered read port; the frontier holds at most CAPACITY = 256 entries. The finish
// step stretches while an earlier result still waits at the output. The table is a
// ping-pong pair: an insert streams the surviving points, with the new point placed in
// order, into the idle bank and swaps banks at the end; a dominated point or a full table
// leaves the active bank untouched. A new beat is taken once the previous one has handed
// its result to the output register, while that result may still wait to be taken.
module skyline_dominance_query_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  sdq_pkg::cmd_e               command_i,
  input  sdq_pkg::coord_t             point_x_i,
  input  sdq_pkg::coord_t             point_y_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output sdq_pkg::status_e            status_o,
  output logic                        found_o,
  output sdq_pkg::coord_t             answer_x_o,
  output sdq_pkg::coord_t             answer_y_o,
  output logic [sdq_pkg::SIZE_W-1:0]  frontier_size_o
);
  import sdq_pkg::*;

  // Control state
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              bank_q, bank_d;
  logic [CNT_W-1:0]  issue_q, issue_d;
  logic              pend_q, pend_d;
  logic [CNT_W-1:0]  wptr_q, wptr_d;
  logic [CNT_W-1:0]  kept_q, kept_d;
  logic              any_dom_q, any_dom_d;
  logic              found_q, found_d;
  logic              placed_q, placed_d;
  logic              buf_valid_q, buf_valid_d;
  logic              out_valid_q, out_valid_d;

  // Payload state
  cmd_e              cmd_q, cmd_d;
  point_t            new_q, new_d;
  point_t            ans_q, ans_d;
  point_t            buf_q, buf_d;
  status_e           res_status_q, res_status_d;
  logic              res_found_q, res_found_d;
  point_t            res_ans_q, res_ans_d;
  logic [SIZE_W-1:0] res_size_q, res_size_d;

  // Table
  point_t            mem0 [CAPACITY];
  point_t            mem1 [CAPACITY];
  point_t            rd0_q, rd1_q;
  logic [IDX_W-1:0]  raddr;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  point_t            wdata;

  point_t            entry;
  logic              stored_dom;
  logic              new_dom;

  // Entry read last cycle, from the active bank
  assign entry      = bank_q ? rd1_q : rd0_q;
  assign stored_dom = (entry.x >= new_q.x) && (entry.y >= new_q.y);
  assign new_dom    = (new_q.x >= entry.x) && (new_q.y >= entry.y);

  assign in_ready_o = (state_q == S_IDLE);

  // Sequencer: accept, scan with one read per cycle, finish and post the result
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    bank_d       = bank_q;
    issue_d      = issue_q;
    pend_d       = 1'b0;
    wptr_d       = wptr_q;
    kept_d       = kept_q;
    any_dom_d    = any_dom_q;
    found_d      = found_q;
    placed_d     = placed_q;
    buf_valid_d  = buf_valid_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    cmd_d        = cmd_q;
    new_d        = new_q;
    ans_d        = ans_q;
    buf_d        = buf_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_ans_d    = res_ans_q;
    res_size_d   = res_size_q;
    raddr        = issue_q[IDX_W-1:0];
    we           = 1'b0;
    waddr        = wptr_q[IDX_W-1:0];
    wdata        = entry;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d       = command_i;
          new_d       = '{x: point_x_i, y: point_y_i};
          ans_d       = '0;
          issue_d     = '0;
          wptr_d      = '0;
          kept_d      = '0;
          any_dom_d   = 1'b0;
          found_d     = 1'b0;
          placed_d    = 1'b0;
          buf_valid_d = 1'b0;
          state_d     = S_SCAN;
        end
      end

      S_SCAN: begin
        // Issue the next read
        if (issue_q < count_q) begin
          issue_d = issue_q + 1'b1;
          pend_d  = 1'b1;
        end
        // Examine the entry that arrived
        if (pend_q) begin
          if (cmd_q == CMD_QUERY) begin
            // First hit on the staircase has the largest x
            if (stored_dom && !found_q) begin
              found_d = 1'b1;
              ans_d   = entry;
            end
          end else begin
            if (stored_dom) begin
              any_dom_d = 1'b1;
            end
            // Stream survivors into the idle bank; the new point goes ahead of the
            // first survivor with smaller x, and later survivors trail by one place
            if (!new_dom) begin
              kept_d = kept_q + 1'b1;
              we     = (wptr_q < CAP_CNT);
              wptr_d = wptr_q + 1'b1;
              if (!placed_q && (entry.x < new_q.x)) begin
                wdata       = new_q;
                buf_d       = entry;
                buf_valid_d = 1'b1;
                placed_d    = 1'b1;
              end else if (buf_valid_q) begin
                wdata = buf_q;
                buf_d = entry;
              end else begin
                wdata = entry;
              end
            end
          end
        end
        if ((issue_q == count_q) && !pend_q) begin
          state_d = S_FINISH;
        end
      end

      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          res_found_d = 1'b0;
          res_ans_d   = '0;
          res_size_d  = SIZE_W'(count_q);
          if (cmd_q == CMD_QUERY) begin
            res_status_d = ST_QUERY;
            res_found_d  = found_q;
            res_ans_d    = ans_q;
          end else if (any_dom_q) begin
            res_status_d = ST_DOMINATED;
          end else if (kept_q >= CAP_CNT) begin
            res_status_d = ST_FULL;
          end else begin
            // Flush the trailing survivor, or append the new point at the low-x end
            res_status_d = ST_INSERTED;
            we           = 1'b1;
            wdata        = buf_valid_q ? buf_q : new_q;
            bank_d       = ~bank_q;
            count_d      = kept_q + 1'b1;
            res_size_d   = SIZE_W'(count_d);
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      bank_q      <= 1'b0;
      issue_q     <= '0;
      pend_q      <= 1'b0;
      wptr_q      <= '0;
      kept_q      <= '0;
      any_dom_q   <= 1'b0;
      found_q     <= 1'b0;
      placed_q    <= 1'b0;
      buf_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      bank_q      <= bank_d;
      issue_q     <= issue_d;
      pend_q      <= pend_d;
      wptr_q      <= wptr_d;
      kept_q      <= kept_d;
      any_dom_q   <= any_dom_d;
      found_q     <= found_d;
      placed_q    <= placed_d;
      buf_valid_q <= buf_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    new_q        <= new_d;
    ans_q        <= ans_d;
    buf_q        <= buf_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_ans_q    <= res_ans_d;
    res_size_q   <= res_size_d;
  end

  // Bank 0: written only while bank 1 is active, so reads and writes never collide
  always_ff @(posedge clk_i) begin
    if (we && bank_q) begin
      mem0[waddr] <= wdata;
    end
    rd0_q <= mem0[raddr];
  end

  // Bank 1: written only while bank 0 is active
  always_ff @(posedge clk_i) begin
    if (we && !bank_q) begin
      mem1[waddr] <= wdata;
    end
    rd1_q <= mem1[raddr];
  end

  // Result beat
  assign out_valid_o     = out_valid_q;
  assign status_o        = res_status_q;
  assign found_o         = res_found_q;
  assign answer_x_o      = res_ans_q.x;
  assign answer_y_o      = res_ans_q.y;
  assign frontier_size_o = res_size_q;

endmodule
